// ===== sv/checked_int32_alu_top_defines.svh =====
// Assertion macros for the checked integer ALU
`ifndef CHECKED_INT32_ALU_TOP_DEFINES_SVH
`define CHECKED_INT32_ALU_TOP_DEFINES_SVH

// Check a property on every rising clock edge, dropped while reset is high
`define CIA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define CIA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/cia_pkg.sv =====
// Types and constants shared by the checked integer ALU files
`timescale 1ns / 1ps

package cia_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int PROD_WIDTH   = 2 * DATA_WIDTH;
   localparam int DIV_STEPS    = DATA_WIDTH;
   // front register, operand preparation, divider cells, result register
   localparam int PIPE_LATENCY = DIV_STEPS + 3;

   localparam logic signed [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]                   opcode;
      logic signed [DATA_WIDTH-1:0] left_operand;
      logic signed [DATA_WIDTH-1:0] right_operand;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result_value;
      logic                         error_flag;
   } rsp_type;

   // item as it travels down the divider chain
   typedef struct packed {
      logic                  valid;
      logic [1:0]            opcode;
      logic [DATA_WIDTH-1:0] value;
      logic                  error;
      logic                  quo_neg;
      logic                  div_zero;
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] quo;
      logic [DATA_WIDTH-1:0] den;
   } cia_stage_type;

endpackage

// ===== sv/checked_int32_alu_top.sv =====
// Top level of the overflow-checked signed integer ALU
`timescale 1ns / 1ps
//
//  channel   ports                    direction  handshake
//  request   start, busy, req_item    in         taken when start && !busy
//  response  rsp_valid, rsp_item      out        one-cycle strobe, no back-pressure
//
//  From acceptance to its strobe every item passes the front register, operand
//  preparation, the chain of one-bit division cells and the result register.
//  One item is taken in every cycle; busy stays low.
//  Reset is synchronous and clears only the valid marks of the pipeline.
//  Results leave in acceptance order; the receiver cannot stall them.

module checked_int32_alu_top import cia_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   // front register: hold the item and its full signed product
   logic                         a_valid_ff;
   req_type                      a_req_ff;
   logic signed [PROD_WIDTH-1:0] a_prod_ff;
   logic signed [PROD_WIDTH-1:0] prod_in;

   // operand preparation
   cia_stage_type                b_in;
   cia_stage_type                b_ff;
   logic [DATA_WIDTH-1:0]        sum;
   logic [DATA_WIDTH-1:0]        dif;
   logic                         na;
   logic                         nb;

   cia_stage_type                chain [DIV_STEPS+1];

   rsp_type                      rsp_in;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_ff;

   // the chain never fills beyond one item per cycle, so never hold off
   assign busy = 1'b0;

   // form the product of the incoming item so it lands beside it
   assign prod_in = req_item.left_operand * req_item.right_operand;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start && !busy;
      end
      a_req_ff <= req_item;
   end

   always_ff @(posedge clock) begin
      a_prod_ff <= prod_in;
   end

   // resolve add, subtract and multiply here; set up magnitudes for divide
   assign na  = a_req_ff.left_operand[DATA_WIDTH-1];
   assign nb  = a_req_ff.right_operand[DATA_WIDTH-1];
   assign sum = a_req_ff.left_operand + a_req_ff.right_operand;
   assign dif = a_req_ff.left_operand - a_req_ff.right_operand;

   always_comb begin
      b_in          = '0;
      b_in.valid    = a_valid_ff && !reset;
      b_in.opcode   = a_req_ff.opcode;
      b_in.quo_neg  = (na != nb);
      b_in.div_zero = (a_req_ff.right_operand == '0);
      b_in.rem      = '0;
      b_in.quo      = na ? -a_req_ff.left_operand : a_req_ff.left_operand;
      b_in.den      = nb ? -a_req_ff.right_operand : a_req_ff.right_operand;
      unique case (opcode_type'(a_req_ff.opcode))
         OP_ADD: begin
            b_in.value = sum;
            b_in.error = (na == nb) && (sum[DATA_WIDTH-1] != na);
         end
         OP_SUB: begin
            b_in.value = dif;
            b_in.error = (na != nb) && (dif[DATA_WIDTH-1] != na);
         end
         OP_MUL: begin
            // overflow when the top bits are not all copies of the sign
            b_in.value = a_prod_ff[DATA_WIDTH-1:0];
            b_in.error = (a_prod_ff[PROD_WIDTH-1:DATA_WIDTH-1]
                          != {(DATA_WIDTH+1){a_prod_ff[DATA_WIDTH-1]}});
         end
         OP_DIV: begin
            // settled at the end of the chain
            b_in.value = '0;
            b_in.error = 1'b0;
         end
         default: begin
            b_in.value = '0;
            b_in.error = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      b_ff <= b_in;
   end

   assign chain[0] = b_ff;

   // advance every item one quotient bit per cell
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      cia_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   // apply the sign to the quotient and drop divide by zero to 0
   always_comb begin
      rsp_in.result_value = chain[DIV_STEPS].value;
      rsp_in.error_flag   = chain[DIV_STEPS].error;
      if (opcode_type'(chain[DIV_STEPS].opcode) == OP_DIV) begin
         if (chain[DIV_STEPS].div_zero) begin
            rsp_in.result_value = '0;
            rsp_in.error_flag   = 1'b1;
         end else if (chain[DIV_STEPS].quo_neg) begin
            rsp_in.result_value = -chain[DIV_STEPS].quo;
            rsp_in.error_flag   = 1'b0;
         end else begin
            rsp_in.result_value = chain[DIV_STEPS].quo;
            rsp_in.error_flag   = chain[DIV_STEPS].quo[DATA_WIDTH-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= chain[DIV_STEPS].valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== sv/cia_cell.sv =====
// One restoring-division cell: produces one quotient bit and passes the item on
`timescale 1ns / 1ps

module cia_cell import cia_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cia_stage_type stage_in,
   output cia_stage_type stage_out
);

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  ge;
   cia_stage_type         stage_in_w;
   cia_stage_type         stage_ff;

   assign shifted = {stage_in.rem, stage_in.quo[DATA_WIDTH-1]};
   assign diff    = shifted - {1'b0, stage_in.den};
   assign ge      = (shifted >= {1'b0, stage_in.den});

   always_comb begin
      stage_in_w       = stage_in;
      // drop the valid mark while reset is high
      stage_in_w.valid = stage_in.valid && !reset;
      stage_in_w.rem   = ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      stage_in_w.quo   = {stage_in.quo[DATA_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in_w;
   end

   assign stage_out = stage_ff;

endmodule

// ===== sv/cia_checker.sv =====
// Port-level checker for the checked integer ALU, bound to the top level
`timescale 1ns / 1ps
`include "checked_int32_alu_top_defines.svh"

module cia_checker import cia_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_item,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   logic took_item;
   logic took_div_zero;
   logic zero_answer;

   assign took_item     = start && !busy;
   assign took_div_zero = took_item && (req_item.opcode == OP_DIV)
                          && (req_item.right_operand == '0);
   assign zero_answer   = rsp_item.error_flag && (rsp_item.result_value == '0);

   `CIA_ASSERT_ALWAYS(a_never_busy, clock, !busy, "busy raised")
   `CIA_ASSERT(a_item_answered, clock, reset, took_item |-> ##PIPE_LATENCY rsp_valid, "item lost")
   `CIA_ASSERT(a_no_invented, clock, reset, rsp_valid |-> $past(took_item, PIPE_LATENCY), "extra")
   `CIA_ASSERT(a_div_zero, clock, reset, rsp_valid && $past(took_div_zero, PIPE_LATENCY) |-> zero_answer, "div0")

endmodule

bind checked_int32_alu_top cia_checker u_cia_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

// ===== test/alu_checker.sv =====
// Checker for the checked integer ALU: predicts each result and compares it
`timescale 1ns / 1ps

module alu_checker import cia_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_item,
   input  logic    rsp_valid,
   input  rsp_type rsp_item,
   output int      fail_count,
   output int      pending_count
);

   rsp_type expected_results[$];

   function automatic rsp_type compute_result(req_type item);
      rsp_type r;
      longint a, b, exact;
      a = longint'(item.left_operand);
      b = longint'(item.right_operand);
      exact = 0;
      r.error_flag = 1'b0;
      case (opcode_type'(item.opcode))
         OP_ADD: exact = a + b;
         OP_SUB: exact = a - b;
         OP_MUL: exact = a * b;
         default: begin
            // zero divisor gives zero; longint division truncates toward zero
            if (b == 0) begin
               exact = 0;
               r.error_flag = 1'b1;
            end else begin
               exact = a / b;
            end
         end
      endcase
      if (exact > longint'(INT_MAX) || exact < longint'(INT_MIN))
         r.error_flag = 1'b1;
      r.result_value = exact[DATA_WIDTH-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && start && !busy)
         expected_results.push_back(compute_result(req_item));
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            want = expected_results.pop_front();
            if (rsp_item.result_value !== want.result_value)
               report_mismatch($sformatf("value got %h want %h",
                  rsp_item.result_value, want.result_value));
            if (rsp_item.error_flag !== want.error_flag)
               report_mismatch($sformatf("error flag got %b want %b",
                  rsp_item.error_flag, want.error_flag));
         end
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== test/tb_top.sv =====
// Stimulus and verdict for the checked integer ALU testbench
`timescale 1ns / 1ps

module tb_top import cia_pkg::*; ();

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;
   int      fail_count;
   int      pending_count;

   checked_int32_alu_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   alu_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Pick an operand biased towards the edges of the signed range
   function automatic logic [DATA_WIDTH-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return INT_MAX;
         1: return INT_MIN;
         2: return '0;
         3: return '1;
         4: return DATA_WIDTH'($urandom_range(0, 8)) - 4;
         5: return DATA_WIDTH'($urandom_range(0, 65535)) - 32768;
         6: return DATA_WIDTH'($urandom_range(46330, 46341));
         default: return $urandom;
      endcase
   endfunction

   // Present one item and hold it until the handshake takes it
   task automatic send_item(logic [1:0] op, logic [DATA_WIDTH-1:0] lhs,
                            logic [DATA_WIDTH-1:0] rhs, bit allow_gaps);
      while (allow_gaps && $urandom_range(0, 99) < 27) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_item <= '{opcode: op, left_operand: lhs, right_operand: rhs};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      logic [DATA_WIDTH-1:0] edge_vals[6];
      int n;
      edge_vals = '{INT_MAX, INT_MIN, '0, '1, 32'd1, 32'h0001_0000};
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation against the corners, incl. divide by zero,
      // most negative over minus one and multiply overflow
      foreach (edge_vals[i]) begin
         send_item(OP_ADD, edge_vals[i], edge_vals[(i + 1) % 6], 1'b0);
         send_item(OP_SUB, edge_vals[i], edge_vals[(i + 3) % 6], 1'b0);
         send_item(OP_MUL, edge_vals[i], edge_vals[(i + 2) % 6], 1'b0);
         send_item(OP_DIV, edge_vals[i], edge_vals[(i + 4) % 6], 1'b0);
      end
      send_item(OP_DIV, INT_MIN, '1, 1'b0);

      // Hold off until everything directed has come back
      drain_results();

      n = 0;
      repeat (1150) begin
         // the middle stretch runs without gaps
         send_item(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                   !(n > 400 && n < 600));
         n++;
      end
      drain_results();
      repeat (PIPE_LATENCY + 5) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
